### hdl/rrs_pkg.sv
// rrs_pkg: shared types and constants for the round robin cpu scheduler
// no dependencies
package rrs_pkg;
    localparam int MAX_PROCS  = 64;
    localparam int TIME_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_PROCS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int PID_BITS   = 7;
    localparam int Q_BITS     = 16;
    localparam int PC_BITS    = 7;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_QUANTUM = 1'b0;
    localparam logic REG_PCOUNT  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // write tables from input item
        logic scan_init; // latch time, clear scan index
        logic scan_rd;   // issue arrival read for scan index
        logic scan_chk;  // compare arrival read data, maybe push
        logic disp_rd;   // pop head, read tables
        logic exec;      // run one unit and emit result
    } rrs_cmd_t;

    typedef struct packed {
        logic scan_last; // scan index reached active count, or time has saturated
    } rrs_sts_t;
endpackage

### hdl/rrs_ctrl.sv
// rrs_ctrl: sequencing state machine of the scheduler
// depends on rrs_pkg
module rrs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            command,
    input  rrs_pkg::rrs_sts_t sts,
    output logic            busy,
    output rrs_pkg::rrs_cmd_t cmd
);
    import rrs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_DISP = 5'b01000,
        S_EXEC = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_LOAD)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                // scan end cycle lets the ring head read settle
                if (sts.scan_last)
                    state_next = S_DISP;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next = S_RD;
            end
            S_DISP:
            begin
                cmd.disp_rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

### hdl/rrs_dp.sv
// rrs_dp: process tables, ready ring and timing arithmetic
// depends on rrs_pkg
module rrs_dp (
    input  logic clk,
    input  logic rst_n,
    input  rrs_pkg::rrs_cmd_t cmd,
    output rrs_pkg::rrs_sts_t sts,
    input  logic [rrs_pkg::Q_BITS-1:0]    cfg_quantum,
    input  logic [rrs_pkg::PC_BITS-1:0]   cfg_pcount,
    input  logic [5:0]                    proc_index,
    input  logic [rrs_pkg::TIME_BITS-1:0] arrival_time,
    input  logic [rrs_pkg::TIME_BITS-1:0] burst_time,
    output logic                          done,
    output logic [15:0]                   tick_time,
    output logic [6:0]                    running_pid,
    output logic                          finished,
    output logic [15:0]                   completion_time,
    output logic [15:0]                   first_run_time,
    output logic [15:0]                   turnaround_time,
    output logic [15:0]                   wait_time,
    output logic                          all_done
);
    import rrs_pkg::*;

    logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
    logic [TIME_BITS-1:0] bur_mem [MAX_PROCS];
    logic [TIME_BITS-1:0] rem_mem [MAX_PROCS];
    logic [TIME_BITS-1:0] st_mem  [MAX_PROCS];
    logic [IDX_BITS-1:0]  ring    [MAX_PROCS];

    logic [TIME_BITS-1:0] time_reg, now_reg;
    logic                 stuck_reg;
    logic                 cur_valid_reg;
    logic [IDX_BITS-1:0]  cur_reg;
    logic [Q_BITS-1:0]    slice_reg;
    logic [CNT_BITS-1:0]  done_cnt_reg;
    logic [IDX_BITS-1:0]  head_reg, tail_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  scan_reg;
    logic [CNT_BITS-1:0]  active;
    logic [TIME_BITS-1:0] arr_rd, bur_rd, rem_rd, st_rd;
    logic [IDX_BITS-1:0]  ring_rd;
    logic [IDX_BITS-1:0]  head_rd;
    logic                 new_disp_reg;
    logic                 disp_now;

    assign active = (cfg_pcount > PC_BITS'(MAX_PROCS)) ? CNT_BITS'(MAX_PROCS)
                                                       : CNT_BITS'(cfg_pcount);
    assign sts.scan_last = stuck_reg || (scan_reg >= active);
    assign disp_now = !cur_valid_reg && (count_reg != '0);

    logic [IDX_BITS-1:0] rd_idx;
    always_comb
    begin
        if (cmd.scan_rd)
            rd_idx = scan_reg[IDX_BITS-1:0];
        else if (cmd.disp_rd && disp_now)
            rd_idx = head_rd;
        else
            rd_idx = cur_reg;
    end

    // table reads, registered
    always_ff @(posedge clk)
    begin
        arr_rd <= arr_mem[rd_idx];
        bur_rd <= bur_mem[rd_idx];
        rem_rd <= rem_mem[rd_idx];
        st_rd  <= st_mem[rd_idx];
        ring_rd <= rd_idx;
        head_rd <= ring[head_reg];
    end

    logic push;
    logic [IDX_BITS-1:0] push_idx;
    logic rem_fin, quantum_hit;
    logic [Q_BITS-1:0] slice_inc;
    logic [TIME_BITS-1:0] ftime, turn, waitv;
    logic [TIME_BITS:0] tdiff, wdiff;

    assign rem_fin = (rem_rd <= TIME_BITS'(1));
    assign slice_inc = (slice_reg != {Q_BITS{1'b1}}) ? slice_reg + 1'b1 : slice_reg;
    assign quantum_hit = (cfg_quantum != '0) && (slice_inc == cfg_quantum);
    assign ftime = (now_reg != TMAX) ? now_reg + 1'b1 : TMAX;
    assign tdiff = {1'b0, ftime} - {1'b0, arr_rd};
    assign turn = tdiff[TIME_BITS] ? '0 : tdiff[TIME_BITS-1:0];
    assign wdiff = {1'b0, turn} - {1'b0, bur_rd};
    assign waitv = wdiff[TIME_BITS] ? '0 : wdiff[TIME_BITS-1:0];

    always_comb
    begin
        push = 1'b0;
        push_idx = ring_rd;
        if (cmd.scan_chk && arr_rd == now_reg)
            push = 1'b1;
        if (cmd.exec && cur_valid_reg && !rem_fin && quantum_hit)
            push = 1'b1;
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arr_mem[proc_index[IDX_BITS-1:0]] <= arrival_time;
            bur_mem[proc_index[IDX_BITS-1:0]] <= burst_time;
            rem_mem[proc_index[IDX_BITS-1:0]] <= burst_time;
        end
        else if (cmd.exec && cur_valid_reg)
            rem_mem[cur_reg] <= rem_fin ? '0 : rem_rd - 1'b1;
        if (cmd.exec && cur_valid_reg && new_disp_reg && rem_rd == bur_rd)
            st_mem[cur_reg] <= now_reg;
        if (push && count_reg < CNT_BITS'(MAX_PROCS))
            ring[tail_reg] <= push_idx;
    end

    logic [TIME_BITS-1:0] first_v;
    assign first_v = (new_disp_reg && rem_rd == bur_rd) ? now_reg : st_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0; now_reg <= '0; stuck_reg <= 1'b0;
            cur_valid_reg <= 1'b0; cur_reg <= '0; slice_reg <= '0;
            done_cnt_reg <= '0; head_reg <= '0; tail_reg <= '0;
            count_reg <= '0; scan_reg <= '0; new_disp_reg <= 1'b0;
            done <= 1'b0; tick_time <= '0; running_pid <= '0; finished <= 1'b0;
            completion_time <= '0; first_run_time <= '0; turnaround_time <= '0;
            wait_time <= '0; all_done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cmd.scan_init)
            begin
                now_reg <= time_reg;
                scan_reg <= '0;
            end
            if (cmd.scan_rd)
                scan_reg <= scan_reg + 1'b1;
            if (push && count_reg < CNT_BITS'(MAX_PROCS))
            begin
                tail_reg <= tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.disp_rd)
            begin
                new_disp_reg <= disp_now;
                if (disp_now)
                begin
                    cur_reg <= head_rd;
                    cur_valid_reg <= 1'b1;
                    slice_reg <= '0;
                    head_reg <= head_reg + 1'b1;
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (cmd.exec)
            begin
                done <= 1'b1;
                tick_time <= now_reg;
                running_pid <= cur_valid_reg ? 7'(cur_reg) + 7'd1 : '0;
                finished <= 1'b0;
                completion_time <= '0; first_run_time <= '0;
                turnaround_time <= '0; wait_time <= '0;
                all_done <= ((done_cnt_reg + CNT_BITS'(cur_valid_reg && rem_fin &&
                              done_cnt_reg < CNT_BITS'(MAX_PROCS))) >= active);
                if (cur_valid_reg)
                begin
                    slice_reg <= slice_inc;
                    if (rem_fin)
                    begin
                        finished <= 1'b1;
                        completion_time <= ftime;
                        first_run_time <= first_v;
                        turnaround_time <= turn;
                        wait_time <= waitv;
                        if (done_cnt_reg < CNT_BITS'(MAX_PROCS))
                            done_cnt_reg <= done_cnt_reg + 1'b1;
                        cur_valid_reg <= 1'b0;
                        slice_reg <= '0;
                    end
                    else if (quantum_hit)
                        cur_valid_reg <= 1'b0;
                end
                if (time_reg != TMAX)
                    time_reg <= time_reg + 1'b1;
                else
                    stuck_reg <= 1'b1;
            end
        end
    end
endmodule

### hdl/round_robin_cpu_scheduler.sv
// round_robin_cpu_scheduler: top level, config registers, controller and datapath
// depends on rrs_pkg, rrs_ctrl, rrs_dp
// A load writes the process tables and leaves the block idle. A tick works on N,
// the active process count (at most 64; N is 0 once time has saturated): the
// arrival scan reads and then checks one table entry per process in turn, then
// come one scan end, one dispatch and one execute state. Its result shows on the
// ports for one cycle with valid high; the receiver cannot stall. Config writes
// are always ready and should only be made while busy is low.
module round_robin_cpu_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [5:0]  proc_index,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        valid,
    output logic [15:0] tick_time,
    output logic [6:0]  running_pid,
    output logic        finished,
    output logic [15:0] completion_time,
    output logic [15:0] first_run_time,
    output logic [15:0] turnaround_time,
    output logic [15:0] wait_time,
    output logic        all_done
);
    import rrs_pkg::*;

    logic [Q_BITS-1:0]  quantum_reg;
    logic [PC_BITS-1:0] pcount_reg;
    rrs_cmd_t cmd;
    rrs_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= '0;
            pcount_reg <= PC_BITS'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_QUANTUM: quantum_reg <= cfg_data;
                REG_PCOUNT:  pcount_reg <= cfg_data[PC_BITS-1:0];
                default: ;
            endcase
        end
    end

    rrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    rrs_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_quantum(quantum_reg), .cfg_pcount(pcount_reg),
        .proc_index(proc_index), .arrival_time(arrival_time),
        .burst_time(burst_time), .done(valid), .tick_time(tick_time),
        .running_pid(running_pid), .finished(finished),
        .completion_time(completion_time), .first_run_time(first_run_time),
        .turnaround_time(turnaround_time), .wait_time(wait_time),
        .all_done(all_done)
    );
endmodule

### hdl/rrs_checker.sv
// rrs_checker: port level assertions for round_robin_cpu_scheduler
// depends on nothing; bound to the top level below
module rrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        command,
    input logic        valid,
    input logic [6:0]  running_pid,
    input logic        finished,
    input logic [15:0] completion_time,
    input logic [15:0] tick_time
);
    a_idle_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
        valid && running_pid == 7'd0 |-> !finished) else $error("finish while idle");
    a_fin_time: assert property (@(posedge clk) disable iff (!rst_n)
        valid && finished && tick_time != 16'hffff |-> completion_time == tick_time + 16'd1)
        else $error("completion time mismatch");
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !command |=> !busy) else $error("load left block busy");
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command |=> busy) else $error("tick not taken");
    a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy) else $error("result while busy");
endmodule

bind round_robin_cpu_scheduler rrs_checker u_rrs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
    .valid(valid), .running_pid(running_pid), .finished(finished),
    .completion_time(completion_time), .tick_time(tick_time)
);
